@@ rtl/bts_pkg.sv @@
// ----------------------------------------------------------------------------
// bts_pkg: shared types and constants for the bitmap task scheduler
// Action codes, controller states and the command/status structs that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package bts_pkg;

	localparam int TASKS      = 32;
	localparam int WAIT_LISTS = 16;
	localparam int TASK_W     = $clog2(TASKS);
	localparam int LIST_W     = (WAIT_LISTS > 1) ? $clog2(WAIT_LISTS) : 1;

	localparam logic [2:0] ACT_SELECT   = 3'd0;
	localparam logic [2:0] ACT_CREATE   = 3'd1;
	localparam logic [2:0] ACT_BLK_LIST = 3'd2;
	localparam logic [2:0] ACT_BLK_DATE = 3'd3;
	localparam logic [2:0] ACT_BLK_BOTH = 3'd4;
	localparam logic [2:0] ACT_SIGNAL   = 3'd5;
	localparam logic [2:0] ACT_ADVANCE  = 3'd6;
	localparam logic [2:0] ACT_UNUSED   = 3'd7;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;      // capture request
		logic exec;      // single-cycle action
		logic scan_start;
		logic scan_step; // visit one deadline task
		logic publish;   // move result into output register
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_advance;
		logic scan_done;
	} ctrl_sts_t;

endpackage

@@ rtl/bts_ctrl.sv @@
// ----------------------------------------------------------------------------
// bts_ctrl: controller state machine
// Sequences capture, execution, the deadline scan and result handoff.
// ----------------------------------------------------------------------------
module bts_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_fire,
	input  logic               out_free,
	input  bts_pkg::ctrl_sts_t sts,
	output logic               busy,
	output bts_pkg::ctrl_cmd_t cmd
);

	bts_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bts_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bts_pkg::ST_IDLE: if (in_fire) state_d = bts_pkg::ST_EXEC;
			bts_pkg::ST_EXEC: state_d = sts.is_advance ? bts_pkg::ST_SCAN : bts_pkg::ST_DONE;
			bts_pkg::ST_SCAN: if (sts.scan_done) state_d = bts_pkg::ST_DONE;
			bts_pkg::ST_DONE: if (out_free) state_d = bts_pkg::ST_IDLE;
			default: state_d = bts_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			bts_pkg::ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = in_fire;
			end
			bts_pkg::ST_EXEC: begin
				cmd.exec       = !sts.is_advance;
				cmd.scan_start = sts.is_advance;
			end
			bts_pkg::ST_SCAN: cmd.scan_step = 1'b1;
			bts_pkg::ST_DONE: cmd.publish = out_free;
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == bts_pkg::ST_IDLE) else $error("load outside idle");
	a_pub_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |=> state_q == bts_pkg::ST_IDLE) else $error("publish not followed by idle");
	a_scan_adv: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_start |=> state_q == bts_pkg::ST_SCAN) else $error("scan not entered");
`endif

endmodule

@@ rtl/bts_dp.sv @@
// ----------------------------------------------------------------------------
// bts_dp: scheduler datapath
// Task bitmaps, wait lists, per-task links and the wake-date memory.
// Advance-date visits one deadline task per cycle, lowest first.
// ----------------------------------------------------------------------------
module bts_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bts_pkg::ctrl_cmd_t              cmd,
	output bts_pkg::ctrl_sts_t              sts,
	input  logic [2:0]                      action,
	input  logic [4:0]                      task_index,
	input  logic [3:0]                      list_id,
	input  logic [31:0]                     date_value,
	output logic                            r_running_valid,
	output logic [4:0]                      r_running_task,
	output logic                            r_found,
	output logic [31:0]                     r_woken_mask,
	output logic                            r_woken_code,
	output logic [31:0]                     r_ready_mask
);

	localparam int T = bts_pkg::TASKS;
	localparam int L = bts_pkg::WAIT_LISTS;
	localparam int TW = bts_pkg::TASK_W;
	localparam int LW = bts_pkg::LIST_W;

	logic [T-1:0]  ready_q, deadline_q, link_vld_q, woken_q, pend_q;
	logic [T-1:0]  wait_q [L];
	logic [LW-1:0] link_q [T];
	logic [31:0]   wake_mem [T];
	logic          run_q, found_q, code_q;
	logic [TW-1:0] cur_q;

	logic [2:0]  act_q;
	logic [4:0]  tidx_q;
	logic [3:0]  list_q;
	logic [31:0] date_q;

	// scan pipeline: the pick stage selects a task, the s1 stage compares its registered wake date
	logic          cmp_vld_s1;
	logic [TW-1:0] cmp_idx_s1;
	logic [31:0]   rd_date_s1;

	function automatic logic [TW-1:0] lowest(input logic [T-1:0] v);
		logic [TW-1:0] n;
		n = '0;
		for (int i = T - 1; i >= 0; i--) begin
			if (v[i]) n = TW'(i);
		end
		return n;
	endfunction

	logic          list_ok;
	logic [LW-1:0] lidx;
	logic [TW-1:0] pick, sig_t;
	logic [T-1:0]  sig_w;

	assign list_ok = ({28'd0, list_q} < 32'(L));
	assign lidx    = LW'(list_q);
	assign pick    = lowest(pend_q);
	assign sig_w   = wait_q[lidx];
	assign sig_t   = lowest(sig_w);

	assign sts.is_advance = (act_q == bts_pkg::ACT_ADVANCE);
	assign sts.scan_done  = (pend_q == '0) && !cmp_vld_s1;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q  <= action;
			tidx_q <= task_index;
			list_q <= list_id;
			date_q <= date_value;
		end
		if (cmd.exec && run_q && (act_q == bts_pkg::ACT_BLK_DATE
			|| ((act_q == bts_pkg::ACT_BLK_BOTH) && list_ok)))
			wake_mem[cur_q] <= date_q;
		if (cmd.exec && run_q && list_ok && (act_q == bts_pkg::ACT_BLK_LIST
			|| act_q == bts_pkg::ACT_BLK_BOTH))
			link_q[cur_q] <= lidx;
		rd_date_s1 <= wake_mem[pick];
		cmp_idx_s1 <= pick;
		if (cmd.publish) begin
			r_running_valid <= run_q;
			r_running_task  <= run_q ? 5'(cur_q) : 5'd0;
			r_found         <= found_q;
			r_woken_mask    <= 32'(woken_q);
			r_woken_code    <= code_q;
			r_ready_mask    <= 32'(ready_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q    <= '0;
			deadline_q <= '0;
			link_vld_q <= '0;
			woken_q    <= '0;
			pend_q     <= '0;
			run_q      <= 1'b0;
			cur_q      <= '0;
			found_q    <= 1'b0;
			code_q     <= 1'b0;
			cmp_vld_s1 <= 1'b0;
			for (int i = 0; i < L; i++) wait_q[i] <= '0;
		end else begin
			if (cmd.load) begin
				found_q <= 1'b0;
				code_q  <= 1'b0;
				woken_q <= '0;
			end
			if (cmd.exec) begin
				case (act_q)
					bts_pkg::ACT_SELECT: begin
						logic [T-1:0] r;
						r = ready_q;
						if (run_q) r[cur_q] = 1'b1;
						if (r != '0) begin
							cur_q <= lowest(r);
							r[lowest(r)] = 1'b0;
							run_q <= 1'b1;
						end else begin
							run_q <= 1'b0;
						end
						ready_q <= r;
					end
					bts_pkg::ACT_CREATE: begin
						if ({27'd0, tidx_q} < 32'(T)) begin
							if (link_vld_q[TW'(tidx_q)])
								wait_q[link_q[TW'(tidx_q)]][TW'(tidx_q)] <= 1'b0;
							link_vld_q[TW'(tidx_q)] <= 1'b0;
							deadline_q[TW'(tidx_q)] <= 1'b0;
							ready_q[TW'(tidx_q)]    <= 1'b1;
						end
					end
					bts_pkg::ACT_BLK_LIST, bts_pkg::ACT_BLK_BOTH: begin
						if (run_q && list_ok) begin
							if (link_vld_q[cur_q] && link_q[cur_q] != lidx)
								wait_q[link_q[cur_q]][cur_q] <= 1'b0;
							wait_q[lidx][cur_q] <= 1'b1;
							link_vld_q[cur_q]   <= 1'b1;
							if (act_q == bts_pkg::ACT_BLK_BOTH) deadline_q[cur_q] <= 1'b1;
							run_q <= 1'b0;
						end
					end
					bts_pkg::ACT_BLK_DATE: begin
						if (run_q) begin
							deadline_q[cur_q] <= 1'b1;
							run_q <= 1'b0;
						end
					end
					bts_pkg::ACT_SIGNAL: begin
						if (list_ok && sig_w != '0) begin
							deadline_q[sig_t]  <= 1'b0;
							wait_q[lidx][sig_t] <= 1'b0;
							link_vld_q[sig_t]  <= 1'b0;
							ready_q[sig_t]     <= 1'b1;
							found_q            <= 1'b1;
							code_q             <= 1'b1;
							woken_q[sig_t]     <= 1'b1;
						end
					end
					default: ;
				endcase
			end
			if (cmd.scan_start) pend_q <= deadline_q;
			cmp_vld_s1 <= cmd.scan_step && (pend_q != '0);
			if (cmd.scan_step && pend_q != '0) pend_q[pick] <= 1'b0;
			if (cmp_vld_s1 && date_q >= rd_date_s1) begin
				deadline_q[cmp_idx_s1] <= 1'b0;
				if (link_vld_q[cmp_idx_s1])
					wait_q[link_q[cmp_idx_s1]][cmp_idx_s1] <= 1'b0;
				link_vld_q[cmp_idx_s1] <= 1'b0;
				ready_q[cmp_idx_s1]    <= 1'b1;
				woken_q[cmp_idx_s1]    <= 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_code_found: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> code_q && $onehot(woken_q)) else $error("found without single wake");
	a_pend_sub: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q & ~deadline_q & ~woken_q) == '0 || cmp_vld_s1)
		else $error("pending task left deadline set");
	a_run_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.exec) && $past(act_q) == bts_pkg::ACT_SELECT && run_q |-> !ready_q[cur_q])
		else $error("running task still ready");
`endif

endmodule

@@ rtl/bitmap_task_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// bitmap_task_scheduler_core: bitmap priority task scheduler
//
//  channel | signals                                         | dir
//  in      | in_valid/in_ready, action, task_index, ...      | request in
//  out     | out_valid/out_ready, running_valid ... ready_mask | result out
//
// One request at a time. A non-advance request passes through execute and done;
// an advance-date request passes through execute, scan and done, the scan making
// one wake-date memory read per task on a deadline (at most 32).
// The next request is accepted the cycle after a result is published; its
// result waits until the output register is taken. Reset clears all
// bitmaps and list sets.
// ----------------------------------------------------------------------------
module bitmap_task_scheduler_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [4:0]  task_index,
	input  logic [3:0]  list_id,
	input  logic [31:0] date_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        running_valid,
	output logic [4:0]  running_task,
	output logic        found,
	output logic [31:0] woken_mask,
	output logic        woken_code,
	output logic [31:0] ready_mask
);

	bts_pkg::ctrl_cmd_t cmd;
	bts_pkg::ctrl_sts_t sts;
	logic busy, in_fire, out_free, out_vld_q;

	assign in_ready  = !busy;
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_vld_q || out_ready;
	assign out_valid = out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.publish) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	bts_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_free(out_free),
		.sts(sts), .busy(busy), .cmd(cmd)
	);

	bts_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.action(action), .task_index(task_index), .list_id(list_id),
		.date_value(date_value),
		.r_running_valid(running_valid), .r_running_task(running_task),
		.r_found(found), .r_woken_mask(woken_mask), .r_woken_code(woken_code),
		.r_ready_mask(ready_mask)
	);

endmodule
